[rtl/lhq_pkg.sv]
// Shared widths and constants for the log-hop audio quantizer.
// No dependencies; imported by every module of the block.
package lhq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 8;
  localparam int CFG_W      = 16;
  localparam int FRAC_W     = 12;
  localparam int QUOT_W     = 16;
  // cube root input: gain * quotient below 2^20, shifted up by 3F - 8 bits
  localparam int ROOT_IN_W  = 20;
  localparam int ROOT_SHIFT = 3 * FRAC_W - 8;
  localparam int ROOT_ARG_W = ROOT_IN_W + ROOT_SHIFT;
  localparam int ROOT_W     = ROOT_ARG_W / 3;
  localparam int RATIO_W    = 16;
  localparam int MUL_A_W    = 40;
  localparam int PROD_W     = MUL_A_W + RATIO_W;
  localparam int OFF_W      = 21;

  localparam logic [SAMPLE_W-1:0] MIDPOINT = {1'b0, {(SAMPLE_W-1){1'b1}}};

  localparam logic [3:0] HOP_ZERO = 4'd4;
  localparam logic [3:0] HOP_POS1 = 4'd5;
  localparam logic [3:0] HOP_NEG1 = 4'd3;
  localparam logic [3:0] HOP_MAX  = 4'd8;

  localparam logic [2:0] REG_INITIAL_STEP  = 3'd0;
  localparam logic [2:0] REG_MINIMUM_STEP  = 3'd1;
  localparam logic [2:0] REG_MAXIMUM_STEP  = 3'd2;
  localparam logic [2:0] REG_RANGE_GAIN    = 3'd3;
  localparam logic [2:0] REG_RATIO_CEILING = 3'd4;
  localparam logic [2:0] REG_RATIO_FLOOR   = 3'd5;
  localparam logic [2:0] REG_LOW_LIMIT     = 3'd6;
  localparam logic [2:0] REG_HIGH_LIMIT    = 3'd7;

endpackage

[rtl/lhq_div.sv]
// Restoring divider, one quotient bit per cycle: distance / step.
// Depends on lhq_pkg.
module lhq_div import lhq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [STEP_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  logic                busy;
  logic [3:0]          count;
  logic [STEP_W-1:0]   dvs;
  logic [STEP_W-1:0]   rem;
  logic [QUOT_W-1:0]   dvd;
  logic [STEP_W:0]     trial;
  logic                fits;

  assign trial = {rem, dvd[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 4'd15;
        dvd <= dividend;
        dvs <= divisor;
        rem <= '0;
      end else if (busy) begin
        rem <= fits ? STEP_W'(trial - {1'b0, dvs}) : trial[STEP_W-1:0];
        dvd <= {dvd[QUOT_W-2:0], fits};
        count <= count - 4'd1;
        if (count == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits collect in the dividend register as it empties
  assign quotient = dvd;

endmodule

[rtl/lhq_cbrt.sv]
// Digit-by-digit integer cube root, one result bit (three argument bits)
// per cycle, with y and y^2 kept incrementally. Depends on lhq_pkg.
module lhq_cbrt import lhq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ROOT_IN_W-1:0] x,
  output logic                 done,
  output logic [ROOT_W-1:0]    root
);

  localparam int REM_W = 38;
  localparam int Y2_W  = 2 * ROOT_W;
  localparam int B_W   = Y2_W + 4;

  logic                  busy;
  logic [3:0]            count;
  logic [ROOT_ARG_W-1:0] arg;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     y;
  logic [Y2_W-1:0]       y2;
  logic [REM_W-1:0]      rem_s;
  logic [B_W-1:0]        base;
  logic [B_W-1:0]        bval;
  logic                  fits;

  always_comb begin
    rem_s = {rem[REM_W-4:0], arg[ROOT_ARG_W-1 -: 3]};
    base  = {y2, 2'b00} + {{(B_W-ROOT_W-1){1'b0}}, y, 1'b0};
    bval  = base + {base[B_W-2:0], 1'b0} + B_W'(1);
    fits  = rem_s >= REM_W'(bval);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 4'(ROOT_W - 1);
        arg <= {x, {ROOT_SHIFT{1'b0}}};
        rem <= '0;
        y <= '0;
        y2 <= '0;
      end else if (busy) begin
        arg <= {arg[ROOT_ARG_W-4:0], 3'b000};
        if (fits) begin
          rem <= rem_s - REM_W'(bval);
          y   <= {y[ROOT_W-2:0], 1'b1};
          // (2y+1)^2 = 4y^2 + 4y + 1
          y2  <= Y2_W'({y2, 2'b00} + {y, 2'b00} + Y2_W'(1));
        end else begin
          rem <= rem_s;
          y   <= {y[ROOT_W-2:0], 1'b0};
          y2  <= {y2[Y2_W-3:0], 2'b00};
        end
        count <= count - 4'd1;
        if (count == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = y;

endmodule

[rtl/lhq_mul.sv]
// Shift-add multiplier, one ratio bit per cycle: product = a * ratio.
// Depends on lhq_pkg.
module lhq_mul import lhq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [RATIO_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  logic               busy;
  logic [3:0]         count;
  logic [PROD_W-1:0]  mcand;
  logic [RATIO_W-1:0] mplier;
  logic [PROD_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 4'(RATIO_W - 1);
        mcand <= PROD_W'(a);
        mplier <= b;
        acc <= '0;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[RATIO_W-1:1]};
        count <= count - 4'd1;
        if (count == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

[rtl/log_hop_audio_quantizer.sv]
// Log-hop audio quantizer top level: control sequencer, state, config.
// Depends on lhq_pkg, lhq_div, lhq_cbrt, lhq_mul.
//
// Input channel (in_valid/in_ready, sample, last_sample) takes one sample
// at a time; output channel (out_valid/out_ready, hop_symbol,
// quantized_value, end_of_signal) returns one result per sample.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data and
// are taken every cycle; write them only while the block is idle.
// A sample whose error stays within half a step, or whose first hop would
// leave the sample range or does not help, ends after that first hop.
// Otherwise the distance division, the cube root of the hop ratio and one
// serial multiply per further hop follow, handled by the serial divider,
// cube root unit and ratio multiplier.
// Reset restores register defaults and starts a new signal (midpoint
// prediction, initial step). A stalled receiver holds the finished result
// in the output register; the next sample is accepted and worked on, and
// waits at its end until the register frees.
module log_hop_audio_quantizer import lhq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          hop_symbol,
  output logic [SAMPLE_W-1:0] quantized_value,
  output logic                end_of_signal,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_HOP1    = 11'b00000000010,
    S_DIV     = 11'b00000000100,
    S_GAIN    = 11'b00000001000,
    S_ROOT_GO = 11'b00000010000,
    S_ROOT    = 11'b00000100000,
    S_CLAMP   = 11'b00001000000,
    S_MUL_GO  = 11'b00010000000,
    S_MUL     = 11'b00100000000,
    S_CAND    = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } state_t;

  function automatic logic [SAMPLE_W-1:0] clamp_lim(input logic signed [22:0] v,
                                                    input logic [SAMPLE_W-1:0] lo,
                                                    input logic [SAMPLE_W-1:0] hi);
    logic [SAMPLE_W-1:0] res;
    if (v > $signed({7'b0, hi})) res = hi;
    else if (v < $signed({7'b0, lo})) res = lo;
    else res = v[SAMPLE_W-1:0];
    return res;
  endfunction

  state_t state;

  // configuration registers
  logic [STEP_W-1:0]   initial_step, minimum_step, maximum_step;
  logic [CFG_W-1:0]    range_gain, ratio_ceiling, ratio_floor;
  logic [SAMPLE_W-1:0] low_limit, high_limit;

  // signal state
  logic [SAMPLE_W-1:0] previous_value;
  logic [STEP_W-1:0]   step_size;
  logic                previous_was_small;
  logic                signal_start;

  // per-sample work registers
  logic [SAMPLE_W-1:0] orig, pred, quantum;
  logic                last;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W:0]   err;
  logic [3:0]          hop;
  logic                pos;
  logic [31:0]         gain_x;
  logic [RATIO_W:0]    r_raw;
  logic [RATIO_W-1:0]  ratio;
  logic [1:0]          k;
  logic [PROD_W-1:0]   prod;

  // unit handshakes
  logic                div_start, div_done;
  logic [QUOT_W-1:0]   div_q;
  logic                root_start, root_done;
  logic [ROOT_W-1:0]   root_y;
  logic                mul_start, mul_done;
  logic [PROD_W-1:0]   mul_p;

  // hop 1 evaluation
  logic [SAMPLE_W:0]   err0, cerr1, cand1;
  logic                pos0, ok1, take1;
  logic [SAMPLE_W:0]   dist_s;
  logic [SAMPLE_W-1:0] hop_dist;

  // hops 2..4
  logic [PROD_W:0]     rsum;
  logic [PROD_W:0]     off_w;
  logic [OFF_W-1:0]    off;
  logic signed [22:0]  cand_v;
  logic [SAMPLE_W-1:0] cand_c;
  logic [SAMPLE_W:0]   cerr;
  logic                small_hop;

  logic                in_xfer, out_load;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    pos0  = orig >= pred;
    err0  = pos0 ? {1'b0, orig} - {1'b0, pred} : {1'b0, pred} - {1'b0, orig};
    ok1   = pos0 ? ({1'b0, pred} + {9'b0, step} <= {1'b0, {SAMPLE_W{1'b1}}})
                 : (pred >= {8'b0, step});
    cand1 = pos0 ? {1'b0, pred} + {9'b0, step} : {1'b0, pred} - {9'b0, step};
    cerr1 = (cand1 >= {1'b0, orig}) ? cand1 - {1'b0, orig} : {1'b0, orig} - cand1;
    take1 = (err0 > {10'b0, step[STEP_W-1:1]}) && ok1 && (cerr1 < err0);
    dist_s = pos0 ? {1'b0, high_limit} - {1'b0, pred} : {1'b0, pred} - {1'b0, low_limit};
    hop_dist = dist_s[SAMPLE_W] ? '0 : dist_s[SAMPLE_W-1:0];
  end

  always_comb begin
    // round half up, shift by k fraction widths
    case (k)
      2'd1: begin
        rsum  = {1'b0, prod} + ((PROD_W+1)'(1) << (FRAC_W - 1));
        off_w = rsum >> FRAC_W;
      end
      2'd2: begin
        rsum  = {1'b0, prod} + ((PROD_W+1)'(1) << (2*FRAC_W - 1));
        off_w = rsum >> (2*FRAC_W);
      end
      default: begin
        rsum  = {1'b0, prod} + ((PROD_W+1)'(1) << (3*FRAC_W - 1));
        off_w = rsum >> (3*FRAC_W);
      end
    endcase
    off    = off_w[OFF_W-1:0];
    cand_v = pos ? $signed({7'b0, pred}) + $signed({2'b0, off})
                 : $signed({7'b0, pred}) - $signed({2'b0, off});
    cand_c = clamp_lim(cand_v, low_limit, high_limit);
    cerr   = (cand_c >= orig) ? {1'b0, cand_c} - {1'b0, orig}
                              : {1'b0, orig} - {1'b0, cand_c};
    small_hop = (hop >= HOP_NEG1) && (hop <= HOP_POS1);
  end

  assign div_start  = (state == S_HOP1) && take1;
  assign root_start = (state == S_ROOT_GO) && (gain_x[31:ROOT_IN_W] == '0);
  assign mul_start  = (state == S_MUL_GO);

  lhq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hop_dist),
    .divisor  (step),
    .done     (div_done),
    .quotient (div_q)
  );

  lhq_cbrt u_cbrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .x     (gain_x[ROOT_IN_W-1:0]),
    .done  (root_done),
    .root  (root_y)
  );

  lhq_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       ((k == 2'd1) ? MUL_A_W'(step) : prod[MUL_A_W-1:0]),
    .b       (ratio),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      initial_step <= 8'd16;
      minimum_step <= 8'd4;
      maximum_step <= 8'd16;
      range_gain <= 16'd256;
      ratio_ceiling <= 16'd12288;
      ratio_floor <= 16'd4096;
      low_limit <= '0;
      high_limit <= '1;
      previous_value <= MIDPOINT;
      step_size <= 8'd16;
      previous_was_small <= 1'b1;
      signal_start <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_INITIAL_STEP:  initial_step <= cfg_data[STEP_W-1:0];
          REG_MINIMUM_STEP:  minimum_step <= cfg_data[STEP_W-1:0];
          REG_MAXIMUM_STEP:  maximum_step <= cfg_data[STEP_W-1:0];
          REG_RANGE_GAIN:    range_gain <= cfg_data;
          REG_RATIO_CEILING: ratio_ceiling <= cfg_data;
          REG_RATIO_FLOOR:   ratio_floor <= cfg_data;
          REG_LOW_LIMIT:     low_limit <= cfg_data;
          REG_HIGH_LIMIT:    high_limit <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            orig <= sample;
            last <= last_sample;
            step <= signal_start ? initial_step : step_size;
            pred <= signal_start ? MIDPOINT : previous_value;
            state <= S_HOP1;
          end
        end
        S_HOP1: begin
          pos <= pos0;
          if (take1) begin
            hop <= pos0 ? HOP_POS1 : HOP_NEG1;
            quantum <= cand1[SAMPLE_W-1:0];
            err <= cerr1;
            state <= S_DIV;
          end else begin
            hop <= HOP_ZERO;
            quantum <= pred;
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            gain_x <= range_gain * div_q;
            state <= S_GAIN;
          end
        end
        S_GAIN: state <= S_ROOT_GO;
        S_ROOT_GO: begin
          if (gain_x[31:ROOT_IN_W] != '0) begin
            r_raw <= {1'b1, {RATIO_W{1'b0}}};
            state <= S_CLAMP;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            r_raw <= (RATIO_W+1)'(root_y);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (r_raw > {1'b0, ratio_ceiling}) ratio <= ratio_ceiling;
          else if (r_raw < {1'b0, ratio_floor}) ratio <= ratio_floor;
          else ratio <= r_raw[RATIO_W-1:0];
          k <= 2'd1;
          state <= S_MUL_GO;
        end
        S_MUL_GO: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            prod <= mul_p;
            state <= S_CAND;
          end
        end
        S_CAND: begin
          if (cerr >= err) begin
            state <= S_FIN;
          end else begin
            hop <= pos ? hop + 4'd1 : hop - 4'd1;
            quantum <= cand_c;
            err <= cerr;
            if (k == 2'd3) begin
              state <= S_FIN;
            end else begin
              k <= k + 2'd1;
              state <= S_MUL_GO;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            hop_symbol <= hop;
            quantized_value <= clamp_lim($signed({7'b0, quantum}), low_limit, high_limit);
            end_of_signal <= last;
            if (last) begin
              previous_value <= MIDPOINT;
              step_size <= initial_step;
              previous_was_small <= 1'b1;
              signal_start <= 1'b1;
            end else begin
              step_size <= (small_hop && previous_was_small && step > minimum_step)
                           ? step - 8'd1 : maximum_step;
              previous_was_small <= small_hop;
              previous_value <= clamp_lim($signed({7'b0, quantum}), low_limit, high_limit);
              signal_start <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hop_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hop_symbol <= HOP_MAX)
    else $error("hop symbol out of range");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_root_owner: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("cube root finished outside its wait state");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_HOP1)
    else $error("accepted sample did not start evaluation");

endmodule
